// ===== design/block_cache_clock_tag_engine_defines.svh =====
// Assertion macros used by the checker of the block cache tag engine.
`ifndef BLOCK_CACHE_CLOCK_TAG_ENGINE_DEFINES_SVH
`define BLOCK_CACHE_CLOCK_TAG_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while reset is low.
`define BCCT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while reset is low.
`define BCCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bcct_pkg.sv =====
// Types and constants of the block cache clock tag engine.
`timescale 1ns / 1ps
package bcct_pkg;

    localparam int CACHE_ENTRIES_DEF = 32;
    localparam int TAG_W             = 32;

    localparam logic [TAG_W-1:0] BLANK_TAG = 32'hFFFF_FFFF;

    // commands
    localparam logic [1:0] CMD_READ      = 2'd0;
    localparam logic [1:0] CMD_WRITE     = 2'd1;
    localparam logic [1:0] CMD_WB_DONE   = 2'd2;
    localparam logic [1:0] CMD_FILL_DONE = 2'd3;

    // result kinds
    localparam logic [2:0] K_HIT       = 3'd0;
    localparam logic [2:0] K_FILL      = 3'd1;
    localparam logic [2:0] K_WRITEBACK = 3'd2;
    localparam logic [2:0] K_NOVICTIM  = 3'd3;
    localparam logic [2:0] K_ACK       = 3'd4;

    typedef struct packed {
        logic [1:0]       command;
        logic [TAG_W-1:0] sector;
        logic [4:0]       entry_index;
    } t_in;

    typedef struct packed {
        logic [2:0]       kind;
        logic [4:0]       slot;
        logic [TAG_W-1:0] block_number;
        logic             fill_pending;
        logic             last;
    } t_out;

    // bit 3 pending, bit 2 pinned, bit 1 dirty, bit 0 accessed
    typedef struct packed {
        logic pending;
        logic pinned;
        logic dirty;
        logic accessed;
    } t_flags;

    typedef struct packed {
        t_flags           flags;
        logic [TAG_W-1:0] tag;
    } t_entry;

    // one clock sweep decision
    typedef struct packed {
        logic   wr;
        logic   wb;
        logic   claim;
        t_flags flags;
    } t_policy;

endpackage

// ===== design/block_cache_clock_tag_engine.sv =====
// Top level of the block cache tag and clock replacement engine.
`timescale 1ns / 1ps
// Usage:
//   Command channel: drive i_req and raise start; the word is taken at the
//   rising edge where start is high and busy is low. Commands are read
//   access, write access, write-back done and fill done.
//   Result channel: each result word sits on o_rsp for one cycle with
//   o_strobe high; o_rsp.last marks the final word of a command. The
//   receiver cannot stall, so the results flow out at the engine's pace.
//   Scan: tags and flags live in one RAM with one read port, so the tag
//   scan reads one entry per cycle. A hit ends the scan at the matching
//   entry; a miss scans all CACHE_ENTRIES entries, then the clock sweep
//   visits one entry per cycle, at most 2*CACHE_ENTRIES entries, and sends
//   a no-victim word if it claims none. Write-back requests come out during
//   the sweep. A completion takes one RAM read before it answers; an
//   out-of-range completion or a no-sector access answers without a RAM read.
//   busy is high from acceptance until the cycle the last word is shown.
//   Reset: i_rst_n low at a rising edge clears the state machine, the clock
//   hand and the per-entry valid bits; an entry never written reads as tag
//   all ones with all flags clear, so no clearing pass is needed.
module block_cache_clock_tag_engine import bcct_pkg::*; #(
    parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_req,
    output logic busy,
    output logic o_strobe,
    output t_out o_rsp
);

    localparam int IW = $clog2(CACHE_ENTRIES);
    localparam int CW = $clog2(2 * CACHE_ENTRIES);
    localparam logic [IW-1:0] LAST_IDX   = IW'(CACHE_ENTRIES - 1);
    localparam logic [CW-1:0] LAST_VISIT = CW'(2 * CACHE_ENTRIES - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CMPL   = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_SWEEP  = 3'd3;
    localparam logic [2:0] S_FAIL   = 3'd4;

    logic [2:0]               r_state, n_state;
    logic [1:0]               r_cmd, n_cmd;
    logic [TAG_W-1:0]         r_sector, n_sector;
    logic [IW-1:0]            r_ptr, n_ptr;
    logic [IW-1:0]            r_hand, n_hand;
    logic [CW-1:0]            r_cnt, n_cnt;
    logic [CACHE_ENTRIES-1:0] r_valid, n_valid;
    logic                     r_rd_valid;
    logic                     r_strobe, n_strobe;
    t_out                     r_rsp, n_rsp;

    logic                     ram_we;
    logic [IW-1:0]            ram_waddr;
    t_entry                   ram_wdata;
    logic [IW-1:0]            ram_raddr;
    logic [$bits(t_entry)-1:0] ram_rdata;

    t_entry  rd_entry;
    t_flags  upd_flags;
    t_policy pol;
    logic [IW-1:0] ptr_next;

    function automatic t_out make_rsp(input logic [2:0] kind, input logic [4:0] slot,
                                      input logic [TAG_W-1:0] blk, input logic pend,
                                      input logic last);
        t_out rsp;
        rsp.kind         = kind;
        rsp.slot         = slot;
        rsp.block_number = blk;
        rsp.fill_pending = pend;
        rsp.last         = last;
        return rsp;
    endfunction

    bcct_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (CACHE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // an entry never written reads as its reset value
    always_comb begin
        if (r_rd_valid) begin
            rd_entry = ram_rdata;
        end else begin
            rd_entry.flags = '0;
            rd_entry.tag   = BLANK_TAG;
        end
    end

    bcct_policy u_policy (
        .i_flags (rd_entry.flags),
        .o_pol   (pol)
    );

    assign ptr_next = (r_ptr == LAST_IDX) ? '0 : r_ptr + 1'b1;

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_sector  = r_sector;
        n_ptr     = r_ptr;
        n_hand    = r_hand;
        n_cnt     = r_cnt;
        n_valid   = r_valid;
        n_strobe  = 1'b0;
        n_rsp     = r_rsp;
        ram_we    = 1'b0;
        ram_waddr = r_ptr;
        ram_wdata = rd_entry;
        ram_raddr = r_ptr;
        upd_flags = rd_entry.flags;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd    = i_req.command;
                    n_sector = i_req.sector;
                    if (i_req.command inside {CMD_WB_DONE, CMD_FILL_DONE}) begin
                        if (32'(i_req.entry_index) >= CACHE_ENTRIES) begin
                            // out-of-range completion: acknowledge, change nothing
                            n_strobe = 1'b1;
                            n_rsp = make_rsp(K_ACK, i_req.entry_index, BLANK_TAG,
                                             1'b0, 1'b1);
                        end else begin
                            n_ptr     = IW'(i_req.entry_index);
                            ram_raddr = IW'(i_req.entry_index);
                            n_state   = S_CMPL;
                        end
                    end else if (i_req.sector == BLANK_TAG) begin
                        n_strobe = 1'b1;
                        n_rsp = make_rsp(K_NOVICTIM, 5'd0, BLANK_TAG, 1'b0, 1'b1);
                    end else begin
                        // start the tag scan at entry zero
                        n_ptr     = '0;
                        ram_raddr = '0;
                        n_state   = S_SEARCH;
                    end
                end
            end

            S_CMPL: begin
                upd_flags.pinned = 1'b0;
                if (r_cmd == CMD_WB_DONE) begin
                    upd_flags.dirty = 1'b0;
                end else begin
                    upd_flags.pending = 1'b0;
                end
                ram_we          = 1'b1;
                ram_wdata.flags = upd_flags;
                n_strobe        = 1'b1;
                n_rsp   = make_rsp(K_ACK, 5'(r_ptr), rd_entry.tag, 1'b0, 1'b1);
                n_state = S_IDLE;
            end

            S_SEARCH: begin
                if (rd_entry.tag == r_sector) begin
                    upd_flags.accessed = 1'b1;
                    if (r_cmd == CMD_WRITE) begin
                        upd_flags.dirty = 1'b1;
                    end
                    ram_we          = 1'b1;
                    ram_wdata.flags = upd_flags;
                    n_strobe        = 1'b1;
                    n_rsp   = make_rsp(K_HIT, 5'(r_ptr), r_sector, upd_flags.pending,
                                       1'b1);
                    n_state = S_IDLE;
                end else if (r_ptr == LAST_IDX) begin
                    // miss: hand over to the clock sweep without a bubble
                    n_ptr     = r_hand;
                    ram_raddr = r_hand;
                    n_cnt     = '0;
                    n_state   = S_SWEEP;
                end else begin
                    n_ptr     = ptr_next;
                    ram_raddr = ptr_next;
                end
            end

            S_SWEEP: begin
                // advance the hand past the visited entry, read the next one
                n_hand    = ptr_next;
                n_ptr     = ptr_next;
                ram_raddr = ptr_next;
                n_cnt     = r_cnt + 1'b1;
                ram_we          = pol.wr;
                ram_wdata.flags = pol.flags;
                if (pol.claim) begin
                    ram_wdata.tag = r_sector;
                    n_strobe      = 1'b1;
                    n_rsp   = make_rsp(K_FILL, 5'(r_ptr), r_sector, 1'b0, 1'b1);
                    n_state = S_IDLE;
                end else begin
                    if (pol.wb) begin
                        n_strobe = 1'b1;
                        n_rsp = make_rsp(K_WRITEBACK, 5'(r_ptr), rd_entry.tag, 1'b0,
                                         1'b0);
                    end
                    if (r_cnt == LAST_VISIT) begin
                        n_state = S_FAIL;
                    end
                end
            end

            S_FAIL: begin
                n_strobe = 1'b1;
                n_rsp    = make_rsp(K_NOVICTIM, 5'd0, r_sector, 1'b0, 1'b1);
                n_state  = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (ram_we) begin
            n_valid[ram_waddr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_hand   <= '0;
            r_valid  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_hand   <= n_hand;
            r_valid  <= n_valid;
            r_strobe <= n_strobe;
        end
    end

    // payload and scan registers: no reset needed
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_sector   <= n_sector;
        r_ptr      <= n_ptr;
        r_cnt      <= n_cnt;
        r_rsp      <= n_rsp;
        r_rd_valid <= r_valid[ram_raddr];
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

// ===== design/bcct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bcct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

// ===== design/bcct_policy.sv =====
// Clock sweep decision for one visited entry.
`timescale 1ns / 1ps
module bcct_policy import bcct_pkg::*; (
    input  t_flags  i_flags,
    output t_policy o_pol
);

    always_comb begin
        o_pol       = '0;
        o_pol.flags = i_flags;
        if (!i_flags.pinned) begin
            o_pol.wr = 1'b1;
            if (i_flags.dirty) begin
                // pin until the write-back completes
                o_pol.wb           = 1'b1;
                o_pol.flags.pinned = 1'b1;
            end else if (i_flags.accessed) begin
                // second chance
                o_pol.flags.accessed = 1'b0;
            end else begin
                o_pol.claim         = 1'b1;
                o_pol.flags         = '0;
                o_pol.flags.pending = 1'b1;
                o_pol.flags.pinned  = 1'b1;
            end
        end
    end

endmodule

// ===== design/bcct_checker.sv =====
// Port-level assertions for the block cache tag engine, bound to the top level.
`timescale 1ns / 1ps
`include "block_cache_clock_tag_engine_defines.svh"
module bcct_checker import bcct_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input t_in  i_req,
    input logic busy,
    input logic o_strobe,
    input t_out o_rsp
);

    logic fill_word;
    logic wb_word;
    logic blank_access;

    assign fill_word    = o_strobe && (o_rsp.kind == K_FILL);
    assign wb_word      = o_strobe && (o_rsp.kind == K_WRITEBACK);
    assign blank_access = start && !busy && (i_req.sector == BLANK_TAG) &&
                          (i_req.command == CMD_READ || i_req.command == CMD_WRITE);

    `BCCT_ASSERT_NOW(a_fill_is_last, fill_word, o_rsp.last, "fill request not last")
    `BCCT_ASSERT_NOW(a_wb_not_last, wb_word, !o_rsp.last, "write-back marked last")
    `BCCT_ASSERT_NOW(a_more_busy, o_strobe && !o_rsp.last, busy, "idle with results pending")
    `BCCT_ASSERT_NOW(a_last_idle, o_strobe && o_rsp.last, !busy, "busy after last word")
    `BCCT_ASSERT_NEXT(a_nosector, blank_access, fill_word || o_strobe, "access not answered")

endmodule

bind block_cache_clock_tag_engine bcct_checker u_checker (.*);
